>>> src/yuv2rgb_pkg.sv
// shared types, constants and coefficient table for the yuyv to rgb converter
`default_nettype none

package yuv2rgb_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned LUMA_W     = 8;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COEF_W     = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned ACC_W      = 27;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 2 * COORD_BITS + 3 * CHAN_W;

  localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(640);
  localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(480);

  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam logic [CHAN_W-1:0] CHAN_SCALE = 8'd220;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [7:0]       delta_t;

  typedef enum logic [1:0] {
    COEF_RV,
    COEF_GV,
    COEF_GU,
    COEF_BU
  } coef_e;

  typedef struct packed {
    coef_e sel;
    logic  sub;
  } mac_ctrl_t;

  // unsigned q1.16 coefficients
  function automatic logic [COEF_W-1:0] coef_value(coef_e sel);
    logic [COEF_W-1:0] val;
    case (sel)
      COEF_RV: val = 17'd89831;
      COEF_GV: val = 17'd45744;
      COEF_GU: val = 17'd22127;
      COEF_BU: val = 17'd113538;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> src/yuyv_to_rgb_pixel_stream.sv
// yuyv word to two rgb pixels with frame position
// after the rv, gv, gu and bu passes the first pixel step registers the first pixel, the second step the second one
// a new word is taken only in the idle step, so not before the four passes through the single
// shared multiplier and both pixel steps of the last word are through
// an output stall holds the sequencer in its pixel step until the slot frees
// reset: counters at row 0 column 0, width 640, height 480, no output pending
`default_nettype none

module yuyv_to_rgb_pixel_stream import yuv2rgb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // luma_first, chroma_blue, luma_second, chroma_red
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_row, pixel_column, red_out, green_out, blue_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_of_pair
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  coord_t                cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RV,
    ST_GV,
    ST_GU,
    ST_BU,
    ST_PIX0,
    ST_PIX1
  } state_e;

  state_e                  state_q;
  logic [LUMA_W-1:0]       luma0_q, luma1_q;
  delta_t                  du_q, dv_q;
  acc_t                    r_term_q, g_term_q, b_term_q;
  coord_t                  width_q, height_q;
  logic                    m_valid_q;
  logic [OUT_DATA_W-1:0]   m_data_q;
  logic                    m_last_q;

  mac_ctrl_t               mac_ctrl;
  acc_t                    mac_acc_in, mac_acc_out;
  logic [LUMA_W-1:0]       luma_sel;
  logic [CHAN_W-1:0]       red, green, blue;
  coord_t                  row, column;
  logic                    slot_free, emit;

  assign slot_free = !m_valid_q || m_axis_tready;
  assign emit      = slot_free && (state_q == ST_PIX0 || state_q == ST_PIX1);
  assign luma_sel  = (state_q == ST_PIX1) ? luma1_q : luma0_q;

  always_comb begin
    mac_ctrl.sel = COEF_RV;
    mac_ctrl.sub = 1'b0;
    mac_acc_in   = '0;
    case (state_q)
      ST_GV: begin
        mac_ctrl.sel = COEF_GV;
        mac_ctrl.sub = 1'b1;
      end
      ST_GU: begin
        mac_ctrl.sel = COEF_GU;
        mac_ctrl.sub = 1'b1;
        mac_acc_in   = g_term_q;
      end
      ST_BU: begin
        mac_ctrl.sel = COEF_BU;
      end
      default: ;
    endcase
  end

  yuv2rgb_mac u_mac (
    .ctrl_i    (mac_ctrl),
    .delta_u_i (du_q),
    .delta_v_i (dv_q),
    .acc_i     (mac_acc_in),
    .acc_o     (mac_acc_out)
  );

  yuv2rgb_chan u_chan_r (.luma_i(luma_sel), .term_i(r_term_q), .chan_o(red));
  yuv2rgb_chan u_chan_g (.luma_i(luma_sel), .term_i(g_term_q), .chan_o(green));
  yuv2rgb_chan u_chan_b (.luma_i(luma_sel), .term_i(b_term_q), .chan_o(blue));

  yuv2rgb_pos u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (emit),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .row_o          (row),
    .column_o       (column)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {blue, green, red, column, row};
        m_last_q  <= (state_q == ST_PIX1);
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_RV;
          end
        end
        ST_RV:   state_q <= ST_GV;
        ST_GV:   state_q <= ST_GU;
        ST_GU:   state_q <= ST_BU;
        ST_BU:   state_q <= ST_PIX0;
        ST_PIX0: begin
          if (slot_free) begin
            state_q <= ST_PIX1;
          end
        end
        ST_PIX1: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      luma0_q <= s_axis_tdata[7:0];
      du_q    <= $signed({~s_axis_tdata[15], s_axis_tdata[14:8]});
      luma1_q <= s_axis_tdata[23:16];
      dv_q    <= $signed({~s_axis_tdata[31], s_axis_tdata[30:24]});
    end
    case (state_q)
      ST_RV:          r_term_q <= mac_acc_out;
      ST_GV, ST_GU:   g_term_q <= mac_acc_out;
      ST_BU:          b_term_q <= mac_acc_out;
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // no new word taken right after one was accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while converting");

  // the second pixel follows once the first is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second pixel missing");

  // scaled channels stay below 220
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:24] <= 8'd219 && m_axis_tdata[39:32] <= 8'd219
                      && m_axis_tdata[47:40] <= 8'd219)
    else $error("channel out of range");

  // words are only taken with no pixel being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !emit)
    else $error("pixel emitted while idle");

endmodule

`default_nettype wire

>>> src/yuv2rgb_mac.sv
// shared multiply-accumulate unit for the chroma terms
`default_nettype none

module yuv2rgb_mac import yuv2rgb_pkg::*; (
  input  mac_ctrl_t ctrl_i,
  input  delta_t    delta_u_i,
  input  delta_t    delta_v_i,
  input  acc_t      acc_i,
  output acc_t      acc_o
);

  logic signed [COEF_W:0] coef_s;
  delta_t                 delta;
  acc_t                   prod;

  always_comb begin
    coef_s = $signed({1'b0, coef_value(ctrl_i.sel)});
    delta  = (ctrl_i.sel == COEF_RV || ctrl_i.sel == COEF_GV) ? delta_v_i : delta_u_i;
    prod   = acc_t'(coef_s) * acc_t'(delta);
    acc_o  = ctrl_i.sub ? (acc_i - prod) : (acc_i + prod);
  end

endmodule

`default_nettype wire

>>> src/yuv2rgb_chan.sv
// per-channel luma add, clamp to 0..255 and 220/256 scaling
`default_nettype none

module yuv2rgb_chan import yuv2rgb_pkg::*; (
  input  logic [LUMA_W-1:0] luma_i,
  input  acc_t              term_i,
  output logic [CHAN_W-1:0] chan_o
);

  acc_t                        sum;
  logic [ACC_W-FRAC_W-2:0]     whole;
  logic [CHAN_W-1:0]           clamped;
  logic [2*CHAN_W-1:0]         scaled;

  always_comb begin
    sum   = $signed({{(ACC_W-LUMA_W-FRAC_W){1'b0}}, luma_i, {FRAC_W{1'b0}}}) + term_i;
    whole = sum[ACC_W-2:FRAC_W];
    if (sum[ACC_W-1]) begin
      clamped = '0;
    end else if (whole > (ACC_W-FRAC_W-1)'(CHAN_MAX)) begin
      clamped = CHAN_MAX;
    end else begin
      clamped = whole[CHAN_W-1:0];
    end
    scaled = {{CHAN_W{1'b0}}, clamped} * {{CHAN_W{1'b0}}, CHAN_SCALE};
    chan_o = scaled[2*CHAN_W-1:CHAN_W];
  end

endmodule

`default_nettype wire

>>> src/yuv2rgb_pos.sv
// row and column counter over the frame
`default_nettype none

module yuv2rgb_pos import yuv2rgb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   advance_i,
  input  coord_t frame_width_i,
  input  coord_t frame_height_i,
  output coord_t row_o,
  output coord_t column_o
);

  coord_t row_q, row_d;
  coord_t column_q, column_d;
  coord_t column_inc, row_inc;

  always_comb begin
    column_inc = column_q + coord_t'(1);
    row_inc    = row_q + coord_t'(1);
    column_d   = column_q;
    row_d      = row_q;
    if (advance_i) begin
      if (column_inc >= frame_width_i) begin
        column_d = '0;
        row_d    = (row_inc >= frame_height_i) ? '0 : row_inc;
      end else begin
        column_d = column_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      column_q <= '0;
    end else begin
      row_q    <= row_d;
      column_q <= column_d;
    end
  end

  assign row_o    = row_q;
  assign column_o = column_q;

endmodule

`default_nettype wire

>>> tb/yuyv_to_rgb_pixel_stream_tb.sv
// self-checking testbench for the yuyv to rgb pixel stream converter
`timescale 1ns / 100ps

module yuyv_to_rgb_pixel_stream_tb;
  import yuv2rgb_pkg::*;

  localparam int MUL_RV = 89831;
  localparam int MUL_GV = 45744;
  localparam int MUL_GU = 22127;
  localparam int MUL_BU = 113538;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    coord_t     row;
    coord_t     col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_addr_i = REG_FRAME_WIDTH;
  coord_t                cfg_wdata_i = '0;

  pixel_t expected_pixels[$];
  coord_t frame_w = WIDTH_RESET;
  coord_t frame_h = HEIGHT_RESET;
  coord_t pos_row = '0;
  coord_t pos_col = '0;
  int     error_count = 0;
  bit     src_idle_on = 1'b1;
  bit     sink_idle_on = 1'b1;
  int     sink_hold_left = 0;

  yuyv_to_rgb_pixel_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // truncate toward zero, clamp, then scale by 220/256
  function automatic logic [7:0] scale_channel(int acc);
    int c;
    if (acc < 0) return 8'd0;
    c = acc / 65536;
    if (c > 255) c = 255;
    return 8'((c * 220) / 256);
  endfunction

  function automatic void push_pixel(logic [7:0] y, int du, int dv, logic last);
    pixel_t px;
    int     ybase;
    ybase    = int'(y) * 65536;
    px.row   = pos_row;
    px.col   = pos_col;
    px.red   = scale_channel(ybase + MUL_RV * dv);
    px.green = scale_channel(ybase - MUL_GV * dv - MUL_GU * du);
    px.blue  = scale_channel(ybase + MUL_BU * du);
    px.last  = last;
    expected_pixels.push_back(px);
    pos_col = pos_col + 1'b1;
    if (pos_col >= frame_w) begin
      pos_col = '0;
      pos_row = pos_row + 1'b1;
      if (pos_row >= frame_h) pos_row = '0;
    end
  endfunction

  function automatic void convert_word(logic [31:0] w);
    int du;
    int dv;
    du = int'(w[15:8]) - 128;
    dv = int'(w[31:24]) - 128;
    push_pixel(w[7:0], du, dv, 1'b0);
    push_pixel(w[23:16], du, dv, 1'b1);
  endfunction

  function automatic logic [31:0] random_word();
    logic [7:0] f[4];
    int         i;
    for (i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0: f[i] = 8'd0;
        1: f[i] = 8'd255;
        2: f[i] = 8'd128;
        default: f[i] = 8'($urandom);
      endcase
    end
    return {f[3], f[2], f[1], f[0]};
  endfunction

  task automatic send_word(logic [31:0] w);
    if (src_idle_on && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    convert_word(w);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr, coord_t val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == REG_FRAME_WIDTH) frame_w = val;
    else frame_h = val;
    @(posedge clk_i);
  endtask

  task automatic set_frame(coord_t w, coord_t h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_random(int n);
    repeat (n) send_word(random_word());
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // color extremes and clamping under the reset frame size
  task automatic test_color_extremes();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h80FF_80FF);
    send_word(32'h8000_8000);
    send_word(32'hFF00_FF80);
    send_word(32'h0000_0080);
    send_word(32'hFF80_FF80);
    send_word(32'h00FF_00FF);
    send_word(32'hFFFF_00FF);
    send_word(32'h0000_FF00);
    send_word(32'hAA55_AA55);
    send_word(32'h55AA_55AA);
  endtask

  // zero width puts every pixel at column 0, zero height keeps row 0
  task automatic test_zero_bounds();
    set_frame(12'd0, 12'd0);
    send_random(3);
    set_frame(12'd0, 12'd5);
    send_random(3);
  endtask

  // counters beyond a bound that was just lowered
  task automatic test_shrink_bounds();
    set_frame(12'd4095, 12'd4095);
    send_random(4);
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd3);
    send_random(2);
    settle();
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    send_random(2);
  endtask

  task automatic test_random_frames();
    set_frame(12'd1, 12'd1);
    send_random(40);
    set_frame(12'd1, 12'd4095);
    send_random(40);
    set_frame(12'd4095, 12'd1);
    send_random(40);
    set_frame(coord_t'($urandom_range(2, 10)), coord_t'($urandom_range(1, 6)));
    send_random(40);
    set_frame(coord_t'($urandom_range(1, 16)), coord_t'($urandom_range(1, 16)));
    send_random(40);
    set_frame(coord_t'($urandom), coord_t'($urandom));
    send_random(40);
  endtask

  task automatic test_no_idle();
    set_frame(coord_t'($urandom_range(3, 12)), coord_t'($urandom_range(2, 8)));
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_random(100);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // long receiver hold while the source keeps offering words
  task automatic test_backpressure();
    set_frame(12'd5, 12'd3);
    src_idle_on    = 1'b0;
    sink_hold_left = 300;
    send_random(50);
    src_idle_on = 1'b1;
  endtask

  always @(posedge clk_i) begin : sink
    pixel_t got;
    pixel_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.row   = m_axis_tdata[11:0];
        got.col   = m_axis_tdata[23:12];
        got.red   = m_axis_tdata[31:24];
        got.green = m_axis_tdata[39:32];
        got.blue  = m_axis_tdata[47:40];
        got.last  = m_axis_tlast;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel transaction, expected none, actual %h", $time,
                   m_axis_tdata);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_row", want.row, got.row);
          check_field("pixel_column", want.col, got.col);
          check_field("red_out", want.red, got.red);
          check_field("green_out", want.green, got.green);
          check_field("blue_out", want.blue, got.blue);
          check_field("last_of_pair", want.last, got.last);
        end
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_idle_on && $urandom_range(99) < 13);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_color_extremes();
    test_zero_bounds();
    test_shrink_bounds();
    test_random_frames();
    test_no_idle();
    test_backpressure();
    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
src/yuv2rgb_pkg.sv
src/yuv2rgb_mac.sv
src/yuv2rgb_chan.sv
src/yuv2rgb_pos.sv
src/yuyv_to_rgb_pixel_stream.sv
tb/yuyv_to_rgb_pixel_stream_tb.sv
